// ===== rtl/core/apsc_pkg.sv =====
package apsc_pkg;

   // Field widths fixed by the interface
   localparam int COORD_W  = 16;
   localparam int CNT_W    = 5;
   localparam int SLOT_W   = 4;
   localparam int STAT_W   = 2;
   localparam int DIFF_W   = COORD_W + 1;
   localparam int PROD_W   = 2 * DIFF_W;
   localparam int DOT_W    = 36;
   localparam int UPC_W    = 4;

   localparam logic [CNT_W-1:0] TARGET_RESET = 5'd10;

   // Four coordinates: [3] w, [2] x, [1] y, [0] z
   typedef logic [3:0][COORD_W-1:0] point_type;

   typedef enum logic [STAT_W-1:0] {
      STATUS_REJECT  = 2'd0,
      STATUS_ACCEPT  = 2'd1,
      STATUS_FULL    = 2'd2,
      STATUS_CLEARED = 2'd3
   } status_type;

   // Sequencing operation of one control word
   typedef enum logic [1:0] {
      SEQ_NEXT     = 2'd0,
      SEQ_DISPATCH = 2'd1,
      SEQ_PAIR     = 2'd2,
      SEQ_DONE     = 2'd3
   } seq_op_type;

   // Which triangle vertex the angle unit works on
   typedef enum logic [1:0] {
      VERT_CAND   = 2'd0,
      VERT_FIRST  = 2'd1,
      VERT_SECOND = 2'd2
   } vert_sel_type;

   typedef struct packed {
      seq_op_type   seq;
      logic         mul_en;
      vert_sel_type vsel;
      logic         chk;
      logic         wr;
      logic         clr;
      logic         emit;
      status_type   status;
   } cw_type;

   // Microprogram addresses
   localparam logic [UPC_W-1:0] UA_IDLE   = 4'd0;
   localparam logic [UPC_W-1:0] UA_RD     = 4'd1;
   localparam logic [UPC_W-1:0] UA_MA     = 4'd2;
   localparam logic [UPC_W-1:0] UA_MB     = 4'd3;
   localparam logic [UPC_W-1:0] UA_MC     = 4'd4;
   localparam logic [UPC_W-1:0] UA_SC     = 4'd5;
   localparam logic [UPC_W-1:0] UA_ACCEPT = 4'd6;
   localparam logic [UPC_W-1:0] UA_REJECT = 4'd7;
   localparam logic [UPC_W-1:0] UA_FULL   = 4'd8;
   localparam logic [UPC_W-1:0] UA_CLEAR  = 4'd9;

   // Control store: one word per step
   function automatic cw_type ucode_rom(input logic [UPC_W-1:0] step);
      cw_type cw;
      cw = '{seq: SEQ_NEXT, mul_en: 1'b0, vsel: VERT_CAND, chk: 1'b0,
             wr: 1'b0, clr: 1'b0, emit: 1'b0, status: STATUS_REJECT};
      unique case (step)
         UA_IDLE: begin
            cw.seq = SEQ_DISPATCH;
         end
         UA_RD: begin
            cw.seq = SEQ_NEXT;
         end
         UA_MA: begin
            cw.mul_en = 1'b1;
            cw.vsel   = VERT_CAND;
         end
         UA_MB: begin
            cw.mul_en = 1'b1;
            cw.vsel   = VERT_FIRST;
            cw.chk    = 1'b1;
         end
         UA_MC: begin
            cw.mul_en = 1'b1;
            cw.vsel   = VERT_SECOND;
            cw.chk    = 1'b1;
         end
         UA_SC: begin
            cw.seq = SEQ_PAIR;
            cw.chk = 1'b1;
         end
         UA_ACCEPT: begin
            cw.seq    = SEQ_DONE;
            cw.wr     = 1'b1;
            cw.emit   = 1'b1;
            cw.status = STATUS_ACCEPT;
         end
         UA_REJECT: begin
            cw.seq    = SEQ_DONE;
            cw.emit   = 1'b1;
            cw.status = STATUS_REJECT;
         end
         UA_FULL: begin
            cw.seq    = SEQ_DONE;
            cw.emit   = 1'b1;
            cw.status = STATUS_FULL;
         end
         UA_CLEAR: begin
            cw.seq    = SEQ_DONE;
            cw.clr    = 1'b1;
            cw.emit   = 1'b1;
            cw.status = STATUS_CLEARED;
         end
         default: begin
            cw.seq = SEQ_DONE;
         end
      endcase
      return cw;
   endfunction

endpackage

// ===== rtl/core/acute_point_set_checker_unit.sv =====
// Acute point set checker. Keeps up to MAX_POINTS 4-D points and tests a
// candidate against every stored pair: each triangle must have three
// strictly acute angles. A clear or a refused (full) item goes from the
// dispatch step straight to its result step. A test visits the stored
// pairs in turn and stops at the first angle that is not acute. With 16
// slots a test meets at most 15 stored points. The pairs share one angle
// unit: four 17x17 multipliers that handle one angle per step. Each pair
// takes one step to read it from the point memory, three multiply steps
// and one step to test the last angle.
// Results appear on the rsp_ ports for exactly one cycle with rsp_strobe
// and cannot be stalled; busy is high from the accepted start until the
// result step.
module acute_point_set_checker_unit #(
   parameter int MAX_POINTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_command,
   input  logic [15:0] req_cand_w,
   input  logic [15:0] req_cand_x,
   input  logic [15:0] req_cand_y,
   input  logic [15:0] req_cand_z,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_stored_index,
   output logic [4:0]  rsp_set_size,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_data
);
   import apsc_pkg::*;

   localparam int AW = $clog2(MAX_POINTS);
   localparam int LW = ((AW > CNT_W) ? AW : CNT_W) + 1;

   // Sequencer and control state
   logic [UPC_W-1:0] upc_ff, upc_in;
   cw_type           cw;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] target_ff;
   logic [AW-1:0]    i_ff, i_in, j_ff, j_in;
   point_type        cand_ff, cand_in;

   // Point memory and its read registers
   point_type        mem [MAX_POINTS];
   point_type        rd_a_ff, rd_b_ff;
   logic [AW-1:0]    wr_addr;

   // Angle unit
   point_type        va, vb, vc;
   logic signed [DIFF_W-1:0] da [4];
   logic signed [DIFF_W-1:0] dc [4];
   logic signed [PROD_W-1:0] prod_ff [4];
   logic signed [PROD_W-1:0] prod_in [4];
   logic signed [DOT_W-1:0]  dot;
   logic             acute;

   // Limits
   logic [LW-1:0]    limit;
   logic             full;
   logic             j_last;
   logic             i_last;

   // Result registers
   logic             strobe_ff;
   status_type       status_ff;
   logic [SLOT_W-1:0] index_ff;
   logic [CNT_W-1:0] size_ff;

   assign cw        = ucode_rom(upc_ff);
   assign busy      = (upc_ff != UA_IDLE);
   assign csr_ready = 1'b1;

   assign limit  = (LW'(target_ff) > LW'(MAX_POINTS)) ? LW'(MAX_POINTS) : LW'(target_ff);
   assign full   = (LW'(count_ff) >= limit);
   assign j_last = ((LW'(j_ff) + LW'(1)) == LW'(count_ff));
   assign i_last = ((LW'(i_ff) + LW'(2)) == LW'(count_ff));
   assign wr_addr = AW'(LW'(count_ff));

   // Pick the vertex and the two other points for this angle
   always_comb begin
      unique case (cw.vsel)
         VERT_FIRST: begin
            vb = rd_a_ff;
            va = rd_b_ff;
            vc = cand_ff;
         end
         VERT_SECOND: begin
            vb = rd_b_ff;
            va = cand_ff;
            vc = rd_a_ff;
         end
         default: begin
            vb = cand_ff;
            va = rd_a_ff;
            vc = rd_b_ff;
         end
      endcase
   end

   // Edge differences and per-coordinate products
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         da[k] = $signed({1'b0, va[k]}) - $signed({1'b0, vb[k]});
         dc[k] = $signed({1'b0, vc[k]}) - $signed({1'b0, vb[k]});
         prod_in[k] = da[k] * dc[k];
      end
   end

   // Dot product of the registered products
   assign dot = DOT_W'(prod_ff[0]) + DOT_W'(prod_ff[1])
              + DOT_W'(prod_ff[2]) + DOT_W'(prod_ff[3]);
   assign acute = !dot[DOT_W-1] && (dot != '0);

   // Step sequencing
   always_comb begin
      upc_in  = upc_ff;
      i_in    = i_ff;
      j_in    = j_ff;
      cand_in = cand_ff;
      unique case (cw.seq)
         SEQ_DISPATCH: begin
            if (start) begin
               cand_in = {req_cand_w, req_cand_x, req_cand_y, req_cand_z};
               i_in    = '0;
               j_in    = AW'(1);
               priority if (req_command) begin
                  upc_in = UA_CLEAR;
               end else if (full) begin
                  upc_in = UA_FULL;
               end else if (count_ff < CNT_W'(2)) begin
                  upc_in = UA_ACCEPT;
               end else begin
                  upc_in = UA_RD;
               end
            end
         end
         SEQ_PAIR: begin
            if (j_last) begin
               if (i_last) begin
                  upc_in = UA_ACCEPT;
               end else begin
                  i_in   = i_ff + AW'(1);
                  j_in   = i_ff + AW'(2);
                  upc_in = UA_RD;
               end
            end else begin
               j_in   = j_ff + AW'(1);
               upc_in = UA_RD;
            end
         end
         SEQ_DONE: begin
            upc_in = UA_IDLE;
         end
         default: begin
            upc_in = upc_ff + UPC_W'(1);
         end
      endcase
      // Drop out on the first non-acute angle
      if (cw.chk && !acute) begin
         upc_in = UA_REJECT;
      end
   end

   // Point count after this step
   always_comb begin
      count_in = count_ff;
      if (cw.clr) begin
         count_in = '0;
      end else if (cw.wr) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff    <= UA_IDLE;
         count_ff  <= '0;
         target_ff <= TARGET_RESET;
         strobe_ff <= 1'b0;
      end else begin
         upc_ff    <= upc_in;
         count_ff  <= count_in;
         strobe_ff <= cw.emit;
         if (csr_valid && csr_ready) begin
            target_ff <= csr_data;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      i_ff    <= i_in;
      j_ff    <= j_in;
      cand_ff <= cand_in;
      if (cw.mul_en) begin
         for (int k = 0; k < 4; k++) begin
            prod_ff[k] <= prod_in[k];
         end
      end
      if (cw.emit) begin
         status_ff <= cw.status;
         index_ff  <= cw.wr ? SLOT_W'(count_ff) : '0;
         size_ff   <= count_in;
      end
   end

   // Point memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (cw.wr) begin
         mem[wr_addr] <= cand_ff;
      end
      rd_a_ff <= mem[i_ff];
      rd_b_ff <= mem[j_ff];
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_status       = status_ff;
   assign rsp_stored_index = index_ff;
   assign rsp_set_size     = size_ff;

endmodule
